### design/drp_pkg.sv
// Package for the ramped drive-straight controller: widths, register indexes,
// pipeline types and the output saturation helper. No dependencies.
package drp_pkg;

  localparam int POS_W   = 24;
  localparam int VEL_W   = 11;
  localparam int HEAD_W  = 17;
  localparam int DRIVE_W = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int ERR_W   = POS_W + 1;    // distance error
  localparam int HERR_W  = HEAD_W + 1;   // heading error
  localparam int DHERR_W = HEAD_W + 2;   // heading error change
  localparam int DRV_W   = ERR_W + 9;    // error times gain
  localparam int HP_W    = HERR_W + 9;
  localparam int HD_W    = DHERR_W + 9;
  localparam int SPEED_W = 32;           // stored speed, 8 fraction bits
  localparam int FIX_W   = DRV_W + 8;    // drive in 1/256 mV
  localparam int CMD_W   = FIX_W + 1;    // command before scaling back

  localparam int unsigned RAMP_STEP_FRAC = 102;
  localparam int unsigned MAX_DRIVE      = 12000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_DISTANCE = 3'd0,
    REG_TARGET_HEADING  = 3'd1,
    REG_DISTANCE_GAIN   = 3'd2,
    REG_HEADING_P_GAIN  = 3'd3,
    REG_HEADING_D_GAIN  = 3'd4,
    REG_MIN_DRIVE       = 3'd5,
    REG_POS_TOLERANCE   = 3'd6,
    REG_SPEED_TOLERANCE = 3'd7
  } reg_idx_t;

  localparam logic ACTION_START = 1'b0;

  // What an item does once the settle check is made.
  typedef enum logic [1:0] {
    KIND_START,
    KIND_HOLD,
    KIND_RUN
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [ERR_W-1:0]   err;
    logic signed [HERR_W-1:0]  herr;
    logic signed [DHERR_W-1:0] dherr;
  } stage_a_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [DRV_W-1:0]   drive;
    logic signed [HP_W-1:0]    hp;
    logic signed [HD_W-1:0]    hd;
  } stage_b_t;

  // Truncating divide by 256, then clamp to the drive range.
  function automatic logic signed [DRIVE_W-1:0] scale_sat(input logic signed [CMD_W-1:0] v);
    logic signed [CMD_W-1:0] q;
    logic signed [CMD_W-1:0] lim;
    begin
      q   = (v + (v[CMD_W-1] ? CMD_W'(255) : CMD_W'(0))) >>> 8;
      lim = CMD_W'(MAX_DRIVE);
      if (q > lim) begin
        scale_sat = lim[DRIVE_W-1:0];
      end else if (q < -lim) begin
        scale_sat = DRIVE_W'(-lim);
      end else begin
        scale_sat = q[DRIVE_W-1:0];
      end
    end
  endfunction

endpackage

### design/drp_if.sv
// Handshake channels of the drive controller: sensor items, command results
// and register writes. Depends on drp_pkg.
interface drp_sample_if;
  import drp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [POS_W-1:0]  pos_front_left;
  logic signed [POS_W-1:0]  pos_back_left;
  logic signed [POS_W-1:0]  pos_front_right;
  logic signed [POS_W-1:0]  pos_back_right;
  logic signed [VEL_W-1:0]  vel_front_left;
  logic signed [VEL_W-1:0]  vel_back_left;
  logic signed [VEL_W-1:0]  vel_front_right;
  logic signed [VEL_W-1:0]  vel_back_right;
  logic signed [HEAD_W-1:0] heading_reading;

  modport source (output valid, action, pos_front_left, pos_back_left, pos_front_right,
                  pos_back_right, vel_front_left, vel_back_left, vel_front_right,
                  vel_back_right, heading_reading, input ready);
  modport sink (input valid, action, pos_front_left, pos_back_left, pos_front_right,
                pos_back_right, vel_front_left, vel_back_left, vel_front_right,
                vel_back_right, heading_reading, output ready);
endinterface

interface drp_result_if;
  import drp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      left_hold;
  logic                      right_hold;
  logic                      done_res;

  modport source (output valid, left_drive, right_drive, left_hold, right_hold, done_res,
                  input ready);
  modport sink (input valid, left_drive, right_drive, left_hold, right_hold, done_res,
                output ready);
endinterface

interface drp_cfg_if;
  import drp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/drive_ramp_heading_pd.sv
// Drive-straight move controller: distance P loop with deadband and slew ramp,
// heading PD correction. Depends on drp_pkg and the channels in drp_if.sv.
//
//  channel  role  payload
//  sample   sink  action, four positions, four velocities, heading_reading
//  result   src   left_drive, right_drive, left_hold, right_hold, done_res
//  cfg      sink  index (register 0..7), data
//
// Four-stage pipeline: input register, error/settle stage, multiply stage,
// ramp and command stage into the result register. An accepted item passes
// through s1 and s2 into the result register; one item per cycle sustained
// while result is ready. Each stage moves on when the one after it is empty or moving, so
// a waiting result stalls the input only once all four registers are full.
// Synchronous reset clears state and loads the register defaults; cfg is always ready.
module drive_ramp_heading_pd (
  input  logic clk,
  input  logic rst,
  drp_sample_if.sink   sample,
  drp_result_if.source result,
  drp_cfg_if.sink      cfg
);
  import drp_pkg::*;

  // configuration
  logic signed [POS_W-1:0]  target_distance;
  logic signed [HEAD_W-1:0] target_heading;
  logic [7:0]               distance_gain;
  logic [7:0]               heading_p_gain;
  logic [7:0]               heading_d_gain;
  logic [13:0]              min_drive;
  logic [9:0]               position_tolerance;
  logic [9:0]               speed_tolerance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance    <= '0;
      target_heading     <= '0;
      distance_gain      <= 8'd20;
      heading_p_gain     <= 8'd40;
      heading_d_gain     <= 8'd2;
      min_drive          <= 14'd2500;
      position_tolerance <= 10'd30;
      speed_tolerance    <= 10'd10;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_TARGET_DISTANCE: target_distance    <= cfg.data[POS_W-1:0];
        REG_TARGET_HEADING:  target_heading     <= cfg.data[HEAD_W-1:0];
        REG_DISTANCE_GAIN:   distance_gain      <= cfg.data[7:0];
        REG_HEADING_P_GAIN:  heading_p_gain     <= cfg.data[7:0];
        REG_HEADING_D_GAIN:  heading_d_gain     <= cfg.data[7:0];
        REG_MIN_DRIVE:       min_drive          <= cfg.data[13:0];
        REG_POS_TOLERANCE:   position_tolerance <= cfg.data[9:0];
        REG_SPEED_TOLERANCE: speed_tolerance    <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  logic s0_valid, s1_valid, s2_valid, out_valid;
  logic ld0, ld1, ld2, ld3;

  assign ld3 = !out_valid || result.ready;
  assign ld2 = !s2_valid || ld3;
  assign ld1 = !s1_valid || ld2;
  assign ld0 = !s0_valid || ld1;
  assign sample.ready = ld0;

  // input register
  logic                     s0_action;
  logic signed [POS_W-1:0]  s0_pos [4];
  logic signed [VEL_W-1:0]  s0_vel [4];
  logic signed [HEAD_W-1:0] s0_heading;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (ld0) begin
      s0_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0 && sample.valid) begin
      s0_action  <= sample.action;
      s0_pos[0]  <= sample.pos_front_left;
      s0_pos[1]  <= sample.pos_back_left;
      s0_pos[2]  <= sample.pos_front_right;
      s0_pos[3]  <= sample.pos_back_right;
      s0_vel[0]  <= sample.vel_front_left;
      s0_vel[1]  <= sample.vel_back_left;
      s0_vel[2]  <= sample.vel_front_right;
      s0_vel[3]  <= sample.vel_back_right;
      s0_heading <= sample.heading_reading;
    end
  end

  // stage A: errors and settle check; move state lives here, in item order
  logic                      active;
  logic signed [HERR_W-1:0]  last_heading_error;
  logic signed [ERR_W-1:0]   last_distance_error;
  logic                      active_next;
  logic signed [HERR_W-1:0]  last_heading_error_next;
  logic signed [ERR_W-1:0]   last_distance_error_next;
  stage_a_t                  a_next;
  stage_a_t                  s1;

  logic signed [POS_W+1:0]   pos_sum;
  logic signed [POS_W+1:0]   pos_avg;
  logic signed [ERR_W-1:0]   err;
  logic signed [HERR_W-1:0]  herr;
  logic [ERR_W-1:0]          derr_mag;
  logic [VEL_W-1:0]          vel_mag;
  logic                      settled;

  always_comb begin
    pos_sum = (POS_W+2)'(s0_pos[0]) + (POS_W+2)'(s0_pos[1])
            + (POS_W+2)'(s0_pos[2]) + (POS_W+2)'(s0_pos[3]);
    // divide by four, truncating toward zero
    pos_avg = (pos_sum + (pos_sum[POS_W+1] ? (POS_W+2)'(3) : (POS_W+2)'(0))) >>> 2;
    err  = ERR_W'(target_distance) - ERR_W'(pos_avg);
    herr = HERR_W'(target_heading) - HERR_W'(s0_heading);

    derr_mag = last_distance_error[ERR_W-1] ? ERR_W'(-last_distance_error)
                                            : ERR_W'(last_distance_error);
    settled = derr_mag <= ERR_W'(position_tolerance);
    for (int i = 0; i < 4; i++) begin
      vel_mag = s0_vel[i][VEL_W-1] ? VEL_W'(-s0_vel[i]) : VEL_W'(s0_vel[i]);
      if (11'(vel_mag) > 11'(speed_tolerance)) begin
        settled = 1'b0;
      end
    end

    active_next              = active;
    last_heading_error_next  = last_heading_error;
    last_distance_error_next = last_distance_error;
    a_next.err   = err;
    a_next.herr  = herr;
    a_next.dherr = DHERR_W'(herr) - DHERR_W'(last_heading_error);
    if (s0_action == ACTION_START) begin
      a_next.kind              = KIND_START;
      active_next              = 1'b1;
      last_heading_error_next  = '0;
      last_distance_error_next = err;
    end else if (!active || settled) begin
      a_next.kind = KIND_HOLD;
      active_next = 1'b0;
    end else begin
      a_next.kind              = KIND_RUN;
      last_heading_error_next  = herr;
      last_distance_error_next = err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid            <= 1'b0;
      active              <= 1'b0;
      last_heading_error  <= '0;
      last_distance_error <= '0;
    end else if (ld1) begin
      s1_valid <= s0_valid;
      if (s0_valid) begin
        active              <= active_next;
        last_heading_error  <= last_heading_error_next;
        last_distance_error <= last_distance_error_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1 && s0_valid) begin
      s1 <= a_next;
    end
  end

  // stage B: the three products
  stage_b_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ld2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && s1_valid) begin
      s2.kind  <= s1.kind;
      s2.drive <= DRV_W'(s1.err) * DRV_W'($signed({1'b0, distance_gain}));
      s2.hp    <= HP_W'(s1.herr) * HP_W'($signed({1'b0, heading_p_gain}));
      s2.hd    <= HD_W'(s1.dherr) * HD_W'($signed({1'b0, heading_d_gain}));
    end
  end

  // stage C: deadband, ramp, correction and scaling
  logic signed [SPEED_W-1:0] last_speed_fixed;
  logic signed [SPEED_W-1:0] last_speed_fixed_next;
  logic signed [DRV_W-1:0]   mind;
  logic signed [DRV_W-1:0]   drive_db;
  logic signed [FIX_W-1:0]   drive_fixed;
  logic signed [FIX_W-1:0]   last_ext;
  logic signed [FIX_W-1:0]   base;
  logic signed [HD_W:0]      corr;
  logic signed [CMD_W-1:0]   corr_fixed;
  logic signed [DRIVE_W-1:0] left_next;
  logic signed [DRIVE_W-1:0] right_next;

  always_comb begin
    mind = $signed(DRV_W'(min_drive));
    drive_db = s2.drive;
    if (s2.drive >= -mind && s2.drive <= DRV_W'(0)) begin
      drive_db = -mind;
    end else if (s2.drive > DRV_W'(0) && s2.drive <= mind) begin
      drive_db = mind;
    end
    drive_fixed = {drive_db, 8'b0};
    last_ext    = FIX_W'(last_speed_fixed);

    if (drive_db > DRV_W'(0) && last_speed_fixed >= SPEED_W'(0)
        && drive_fixed > last_ext) begin
      base = last_ext + FIX_W'(RAMP_STEP_FRAC);
    end else if (drive_db < DRV_W'(0) && last_speed_fixed <= SPEED_W'(0)
                 && drive_fixed < last_ext) begin
      base = last_ext - FIX_W'(RAMP_STEP_FRAC);
    end else begin
      base = drive_fixed;
    end

    // stored speed saturates to 32 bits
    if (base > FIX_W'(32'sh7FFF_FFFF)) begin
      last_speed_fixed_next = 32'sh7FFF_FFFF;
    end else if (base < FIX_W'(-33'sh8000_0000)) begin
      last_speed_fixed_next = -32'sh8000_0000;
    end else begin
      last_speed_fixed_next = base[SPEED_W-1:0];
    end

    corr       = (HD_W+1)'(s2.hp) + (HD_W+1)'(s2.hd);
    corr_fixed = CMD_W'(corr) <<< 8;
    left_next  = scale_sat(CMD_W'(base) + corr_fixed);
    right_next = scale_sat(CMD_W'(base) - corr_fixed);
  end

  logic signed [DRIVE_W-1:0] res_left;
  logic signed [DRIVE_W-1:0] res_right;
  logic                      res_left_hold;
  logic                      res_right_hold;
  logic                      res_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      last_speed_fixed <= '0;
    end else if (ld3) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        case (s2.kind)
          KIND_START: last_speed_fixed <= '0;
          KIND_RUN:   last_speed_fixed <= last_speed_fixed_next;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld3 && s2_valid) begin
      case (s2.kind)
        KIND_RUN: begin
          res_left       <= left_next;
          res_right      <= right_next;
          res_left_hold  <= left_next == '0;
          res_right_hold <= right_next == '0;
          res_done       <= 1'b0;
        end
        KIND_HOLD: begin
          res_left       <= '0;
          res_right      <= '0;
          res_left_hold  <= 1'b1;
          res_right_hold <= 1'b1;
          res_done       <= 1'b1;
        end
        default: begin
          res_left       <= '0;
          res_right      <= '0;
          res_left_hold  <= 1'b0;
          res_right_hold <= 1'b0;
          res_done       <= 1'b0;
        end
      endcase
    end
  end

  assign result.valid       = out_valid;
  assign result.left_drive  = res_left;
  assign result.right_drive = res_right;
  assign result.left_hold   = res_left_hold;
  assign result.right_hold  = res_right_hold;
  assign result.done_res    = res_done;

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for drive_ramp_heading_pd: directed moves, then random moves under
// four handshake pacing modes, checked against an in-bench command predictor.
// Depends on drp_pkg, the channels in drp_if.sv and the controller itself.
module tb;
  import drp_pkg::*;

  localparam logic ACTION_TICK = !ACTION_START;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;
  localparam longint RAMP_Q8 = RAMP_STEP_FRAC;
  localparam longint DRV_LIMIT = MAX_DRIVE;
  localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));
  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint VEL_MIN = -(longint'(1) << (VEL_W - 1));
  localparam longint VEL_MAX = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint HEAD_MIN = -(longint'(1) << (HEAD_W - 1));
  localparam longint HEAD_MAX = (longint'(1) << (HEAD_W - 1)) - 1;
  localparam longint SPEED_MIN = -(longint'(1) << (SPEED_W - 1));
  localparam longint SPEED_MAX = (longint'(1) << (SPEED_W - 1)) - 1;

  typedef struct packed {
    logic                     action;
    logic signed [POS_W-1:0]  pfl;
    logic signed [POS_W-1:0]  pbl;
    logic signed [POS_W-1:0]  pfr;
    logic signed [POS_W-1:0]  pbr;
    logic signed [VEL_W-1:0]  vfl;
    logic signed [VEL_W-1:0]  vbl;
    logic signed [VEL_W-1:0]  vfr;
    logic signed [VEL_W-1:0]  vbr;
    logic signed [HEAD_W-1:0] heading;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_cmd;
    logic signed [DRIVE_W-1:0] right_cmd;
    logic                      left_hold;
    logic                      right_hold;
    logic                      done_flag;
  } cmd_t;

  logic clk;
  logic rst;

  drp_sample_if sample_ch ();
  drp_result_if result_ch ();
  drp_cfg_if    cfg_ch ();

  drive_ramp_heading_pd uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // predictor copy of the registers and move state
  logic signed [POS_W-1:0]   tgt_dist;
  logic signed [HEAD_W-1:0]  tgt_head;
  logic [7:0]                dist_gain;
  logic [7:0]                hp_gain;
  logic [7:0]                hd_gain;
  logic [13:0]               min_drv;
  logic [9:0]                pos_tol;
  logic [9:0]                spd_tol;
  logic                      in_move;
  logic signed [SPEED_W-1:0] speed_q8;
  logic signed [HERR_W-1:0]  prev_herr;
  logic signed [ERR_W-1:0]   prev_derr;

  cmd_t pending_cmds[$];
  int   errors;
  int   items_sent;
  int   moves_run;
  int   settles;
  int   dones_seen;
  int   holds_seen;
  int   gap_pct;
  int   stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Cycle limit reached with %0d commands outstanding", pending_cmds.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint rand_between(input longint lo, input longint hi);
    return lo + longint'($urandom_range(0, 32'(hi - lo)));
  endfunction

  // extremes turn up one time in four
  function automatic longint pick(input longint lo, input longint hi);
    int unsigned r;
    r = $urandom_range(7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return rand_between(lo, hi);
  endfunction

  task automatic reset_model();
    tgt_dist  = '0;
    tgt_head  = '0;
    dist_gain = 8'd20;
    hp_gain   = 8'd40;
    hd_gain   = 8'd2;
    min_drv   = 14'd2500;
    pos_tol   = 10'd30;
    spd_tol   = 10'd10;
    in_move   = 1'b0;
    speed_q8  = '0;
    prev_herr = '0;
    prev_derr = '0;
  endtask

  function automatic cmd_t predict_command(input sample_t s);
    cmd_t   c;
    longint pos_sum, derr, herr, drv, drv_q8, last, base, corr, lv, rv, mn;
    bit     settled;
    c = '0;
    pos_sum = longint'($signed(s.pfl)) + longint'($signed(s.pbl))
            + longint'($signed(s.pfr)) + longint'($signed(s.pbr));
    derr = longint'($signed(tgt_dist)) - pos_sum / 4;
    if (s.action == ACTION_START) begin
      in_move   = 1'b1;
      speed_q8  = '0;
      prev_herr = '0;
      prev_derr = ERR_W'(derr);
      return c;
    end
    if (in_move) begin
      settled = mag(longint'($signed(prev_derr))) <= longint'(pos_tol)
             && mag(longint'($signed(s.vfl))) <= longint'(spd_tol)
             && mag(longint'($signed(s.vbl))) <= longint'(spd_tol)
             && mag(longint'($signed(s.vfr))) <= longint'(spd_tol)
             && mag(longint'($signed(s.vbr))) <= longint'(spd_tol);
      if (settled) begin
        in_move = 1'b0;
        settles++;
      end
    end
    if (!in_move) begin
      c.left_hold  = 1'b1;
      c.right_hold = 1'b1;
      c.done_flag  = 1'b1;
      return c;
    end
    herr = longint'($signed(tgt_head)) - longint'($signed(s.heading));
    mn   = longint'(min_drv);
    drv  = derr * longint'(dist_gain);
    // deadband: zero lands on the negative limit first
    if (drv >= -mn && drv <= 0) drv = -mn;
    if (drv >= 0 && drv <= mn) drv = mn;
    drv_q8 = drv * 256;
    last   = longint'($signed(speed_q8));
    if (drv > 0 && last >= 0 && drv_q8 > last) begin
      base = last + RAMP_Q8;
    end else if (drv < 0 && last <= 0 && drv_q8 < last) begin
      base = last - RAMP_Q8;
    end else begin
      base = drv_q8;
    end
    speed_q8 = SPEED_W'(clamp(base, SPEED_MIN, SPEED_MAX));
    corr = (herr * longint'(hp_gain)
         + (herr - longint'($signed(prev_herr))) * longint'(hd_gain)) * 256;
    lv = clamp((base + corr) / 256, -DRV_LIMIT, DRV_LIMIT);
    rv = clamp((base - corr) / 256, -DRV_LIMIT, DRV_LIMIT);
    prev_herr = HERR_W'(herr);
    prev_derr = ERR_W'(derr);
    c.left_cmd   = DRIVE_W'(lv);
    c.right_cmd  = DRIVE_W'(rv);
    c.left_hold  = (lv == 0);
    c.right_hold = (rv == 0);
    return c;
  endfunction

  task automatic load_sample(input sample_t s);
    sample_ch.action          <= s.action;
    sample_ch.pos_front_left  <= s.pfl;
    sample_ch.pos_back_left   <= s.pbl;
    sample_ch.pos_front_right <= s.pfr;
    sample_ch.pos_back_right  <= s.pbr;
    sample_ch.vel_front_left  <= s.vfl;
    sample_ch.vel_back_left   <= s.vbl;
    sample_ch.vel_front_right <= s.vfr;
    sample_ch.vel_back_right  <= s.vbr;
    sample_ch.heading_reading <= s.heading;
  endtask

  // valid is left high after the handshake so back-to-back items need no toggle
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < gap_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    load_sample(s);
    do @(posedge clk); while (!sample_ch.ready);
    pending_cmds.push_back(predict_command(s));
    items_sent++;
  endtask

  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input reg_idx_t r, input longint v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= r;
    cfg_ch.data  <= CFG_DATA_W'(v);
    do @(posedge clk); while (!cfg_ch.ready);
    case (r)
      REG_TARGET_DISTANCE: tgt_dist = POS_W'(v);
      REG_TARGET_HEADING:  tgt_head = HEAD_W'(v);
      REG_DISTANCE_GAIN:   dist_gain = 8'(v);
      REG_HEADING_P_GAIN:  hp_gain = 8'(v);
      REG_HEADING_D_GAIN:  hd_gain = 8'(v);
      REG_MIN_DRIVE:       min_drv = 14'(v);
      REG_POS_TOLERANCE:   pos_tol = 10'(v);
      REG_SPEED_TOLERANCE: spd_tol = 10'(v);
      default: ;
    endcase
  endtask

  task automatic write_regs(input longint td, input longint th, input longint dg,
                            input longint hp, input longint hd, input longint md,
                            input longint ptol, input longint stol);
    put_reg(REG_TARGET_DISTANCE, td);
    put_reg(REG_TARGET_HEADING, th);
    put_reg(REG_DISTANCE_GAIN, dg);
    put_reg(REG_HEADING_P_GAIN, hp);
    put_reg(REG_HEADING_D_GAIN, hd);
    put_reg(REG_MIN_DRIVE, md);
    put_reg(REG_POS_TOLERANCE, ptol);
    put_reg(REG_SPEED_TOLERANCE, stol);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic sample_t uniform_sample(input logic act, input longint p,
                                             input longint v, input longint h);
    sample_t s;
    s.action  = act;
    s.pfl     = POS_W'(p);
    s.pbl     = POS_W'(p);
    s.pfr     = POS_W'(p);
    s.pbr     = POS_W'(p);
    s.vfl     = VEL_W'(v);
    s.vbl     = VEL_W'(v);
    s.vfr     = VEL_W'(v);
    s.vbr     = VEL_W'(v);
    s.heading = HEAD_W'(h);
    return s;
  endfunction

  function automatic sample_t move_sample(input logic act, input longint avg,
                                          input longint jit, input longint vmax,
                                          input longint h);
    sample_t s;
    s.action  = act;
    s.pfl     = POS_W'(clamp(avg + rand_between(-jit, jit), POS_MIN, POS_MAX));
    s.pbl     = POS_W'(clamp(avg + rand_between(-jit, jit), POS_MIN, POS_MAX));
    s.pfr     = POS_W'(clamp(avg + rand_between(-jit, jit), POS_MIN, POS_MAX));
    s.pbr     = POS_W'(clamp(avg + rand_between(-jit, jit), POS_MIN, POS_MAX));
    s.vfl     = VEL_W'(clamp(rand_between(-vmax, vmax), VEL_MIN, VEL_MAX));
    s.vbl     = VEL_W'(clamp(rand_between(-vmax, vmax), VEL_MIN, VEL_MAX));
    s.vfr     = VEL_W'(clamp(rand_between(-vmax, vmax), VEL_MIN, VEL_MAX));
    s.vbr     = VEL_W'(clamp(rand_between(-vmax, vmax), VEL_MIN, VEL_MAX));
    s.heading = HEAD_W'(clamp(h, HEAD_MIN, HEAD_MAX));
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s.action  = logic'($urandom_range(1));
    s.pfl     = POS_W'(rand_between(POS_MIN, POS_MAX));
    s.pbl     = POS_W'(rand_between(POS_MIN, POS_MAX));
    s.pfr     = POS_W'(rand_between(POS_MIN, POS_MAX));
    s.pbr     = POS_W'(rand_between(POS_MIN, POS_MAX));
    s.vfl     = VEL_W'(rand_between(VEL_MIN, VEL_MAX));
    s.vbl     = VEL_W'(rand_between(VEL_MIN, VEL_MAX));
    s.vfr     = VEL_W'(rand_between(VEL_MIN, VEL_MAX));
    s.vbr     = VEL_W'(rand_between(VEL_MIN, VEL_MAX));
    s.heading = HEAD_W'(rand_between(HEAD_MIN, HEAD_MAX));
    return s;
  endfunction

  task automatic compare_field(input string what, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $display("%0t %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // result side: random stalls and the comparison against the oldest expectation
  initial begin
    cmd_t want;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_ch.valid && result_ch.ready) begin
        if (pending_cmds.size() == 0) begin
          errors++;
          $display("%0t command item with none expected", $time);
        end else begin
          want = pending_cmds.pop_front();
          compare_field("left_drive", longint'($signed(want.left_cmd)),
                        longint'($signed(result_ch.left_drive)));
          compare_field("right_drive", longint'($signed(want.right_cmd)),
                        longint'($signed(result_ch.right_drive)));
          compare_field("left_hold", want.left_hold, result_ch.left_hold);
          compare_field("right_hold", want.right_hold, result_ch.right_hold);
          compare_field("done_res", want.done_flag, result_ch.done_res);
          dones_seen += result_ch.done_res;
          holds_seen += result_ch.left_hold & result_ch.right_hold;
        end
      end
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // reset register values; idle tick, then start and ticks at the field extremes
  task automatic test_extremes();
    send_sample(uniform_sample(ACTION_TICK, 12345, 3, 100));
    send_sample(uniform_sample(ACTION_START, POS_MAX, 0, 0));
    send_sample(uniform_sample(ACTION_TICK, POS_MAX, VEL_MAX, HEAD_MAX));
    // sign flip against a negative ramp drives the stored speed into saturation
    send_sample(uniform_sample(ACTION_TICK, POS_MIN, VEL_MIN, HEAD_MIN));
    send_sample(uniform_sample(ACTION_TICK, POS_MIN, VEL_MIN, HEAD_MIN));
  endtask

  // zero drive takes the negative limit, small drives snap to the limit
  task automatic test_deadband();
    wait_idle();
    write_regs(1000, 0, 1, 0, 0, 2500, 0, 0);
    send_sample(uniform_sample(ACTION_START, 1000, 0, 0));
    send_sample(uniform_sample(ACTION_TICK, 1000, 1, 0));
    send_sample(uniform_sample(ACTION_TICK, 0, 1, 0));
    send_sample(uniform_sample(ACTION_TICK, 1001, 1, 0));
    wait_idle();
    write_regs(0, 0, 1, 0, 0, 0, 0, 0);
    send_sample(uniform_sample(ACTION_START, 0, 0, 0));
    send_sample(uniform_sample(ACTION_TICK, 0, 1, 0));
  endtask

  // tolerances are inclusive on both the stored error and the wheel speeds
  task automatic test_settle();
    sample_t s;
    wait_idle();
    write_regs(1000, 0, 20, 40, 2, 2500, 5, 10);
    send_sample(uniform_sample(ACTION_START, 995, 0, 0));
    s = uniform_sample(ACTION_TICK, 995, 10, 0);
    s.vbr = VEL_W'(11);
    send_sample(s);
    s.vbl = -VEL_W'(10);
    s.vbr = -VEL_W'(10);
    send_sample(s);
    send_sample(uniform_sample(ACTION_TICK, 995, 0, 0));
    send_sample(uniform_sample(ACTION_START, 994, 0, 0));
    send_sample(uniform_sample(ACTION_TICK, 994, 0, 0));
  endtask

  // full gains on the widest heading errors, both signs
  task automatic test_heading();
    wait_idle();
    write_regs(POS_MIN, HEAD_MIN, 255, 255, 255, 12000, 0, 0);
    send_sample(uniform_sample(ACTION_START, POS_MAX, 0, 0));
    send_sample(uniform_sample(ACTION_TICK, POS_MAX, 5, HEAD_MAX));
    send_sample(uniform_sample(ACTION_TICK, POS_MAX, 5, HEAD_MIN));
    wait_idle();
    write_regs(POS_MAX, HEAD_MAX, 0, 255, 0, 0, 1023, 1023);
    send_sample(uniform_sample(ACTION_START, POS_MIN, 0, 0));
    send_sample(uniform_sample(ACTION_TICK, POS_MIN, 0, HEAD_MIN));
  endtask

  // one move: start, approach the target, arrive, slow down, settle, idle tick; some moves are cut short
  task automatic run_move();
    longint td, th, pt, st, origin, avg, jit, vmax, hjit;
    int     n;
    bit     cut_short;
    td = $urandom_range(1) ? pick(POS_MIN, POS_MAX) : rand_between(-3000, 3000);
    th = pick(HEAD_MIN, HEAD_MAX);
    pt = pick(0, 1023);
    st = pick(0, 1023);
    wait_idle();
    write_regs(td, th, pick(0, 255),
               ($urandom_range(2) == 0) ? pick(0, 255) : rand_between(0, 12),
               ($urandom_range(2) == 0) ? pick(0, 255) : rand_between(0, 12),
               pick(0, 12000), pt, st);
    moves_run++;
    origin = rand_between(-200, 200);
    hjit = ($urandom_range(3) == 0) ? HEAD_MAX - HEAD_MIN : rand_between(0, 300);
    n = $urandom_range(3, 24);
    cut_short = ($urandom_range(4) == 0);
    send_sample(move_sample(ACTION_START, origin, 50, VEL_MAX, th));
    for (int k = 1; k <= n + 2; k++) begin
      if (cut_short && k > n / 2) break;
      if (k < n) begin
        avg  = origin + (td - origin) * k / n;
        jit  = 64;
        vmax = $urandom_range(1) ? VEL_MAX : 100;
      end else begin
        avg  = td;
        jit  = pt / 2;
        vmax = (k == n) ? VEL_MAX : st;
      end
      if ($urandom_range(11) == 0) begin
        send_sample(random_sample());
      end else begin
        send_sample(move_sample(ACTION_TICK, avg, jit, vmax,
                                th + rand_between(-hjit, hjit)));
      end
    end
    repeat ($urandom_range(2)) send_sample(random_sample());
  endtask

  task automatic test_random_traffic(input int gap, input int stall, input int quota);
    int first;
    first = items_sent;
    gap_pct = gap;
    stall_pct = stall;
    while (items_sent - first < quota) run_move();
  endtask

  initial begin
    sample_t blank;
    blank = '0;
    errors = 0;
    items_sent = 0;
    moves_run = 0;
    settles = 0;
    dones_seen = 0;
    holds_seen = 0;
    gap_pct = 0;
    stall_pct = 0;
    reset_model();
    rst <= 1'b1;
    sample_ch.valid <= 1'b0;
    load_sample(blank);
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_TARGET_DISTANCE;
    cfg_ch.data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_extremes();
    test_deadband();
    test_settle();
    test_heading();
    test_random_traffic(0, 0, 425);
    test_random_traffic(64, 0, 425);
    test_random_traffic(0, 64, 425);
    test_random_traffic(30, 30, 425);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drove %0d items through %0d random moves plus directed cases;", items_sent,
             moves_run);
    $display("%0d moves settled, %0d done and %0d double-hold commands compared.", settles,
             dones_seen, holds_seen);
    if (errors == 0 && pending_cmds.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
